// ===== rtl/core/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int KEY_W        = 32;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 32;
   localparam int CFG_W        = 5;

   localparam logic [CFG_W-1:0]   CAP_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

endpackage

// ===== rtl/core/lfu_cache_table_top.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_table_top
// Fully associative key/value table, LFU replacement with LRU tie break.
// ----------------------------------------------------------------------------
// The result strobe is registered out of the decide state, which follows the scan pass.
// A get miss or a put with capacity 0 returns to idle after decide; other items
//   add an update pass, as the RAM is read one entry at a time. No start is taken while busy.
// Reset: synchronous; all entries invalid, capacity register back to 16.
// The result receiver cannot stall; each result strobes for one cycle.
module lfu_cache_table_top #(
   parameter int CAPACITY = lfu_pkg::DEF_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_action,
   input  logic [lfu_pkg::KEY_W-1:0]   req_lookup_key,
   input  logic [lfu_pkg::VALUE_W-1:0] req_write_value,
   output logic                        rsp_strobe,
   output logic                        rsp_hit,
   output logic [lfu_pkg::VALUE_W-1:0] rsp_read_value,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lfu_pkg::CFG_W-1:0]   csr_write_data
);

   localparam int IDXW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNTW   = $clog2(CAPACITY + 1);
   localparam int RW     = IDXW;
   localparam int WORD_W = lfu_pkg::KEY_W + lfu_pkg::VALUE_W + lfu_pkg::COUNT_W + RW;
   localparam logic [CNTW-1:0] CAP_N = CNTW'(CAPACITY);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_UPD    = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [lfu_pkg::CFG_W-1:0] cap_ff, cap_in;

   logic                        act_ff, act_in;
   logic [lfu_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [lfu_pkg::VALUE_W-1:0] wval_ff, wval_in;

   logic found_ff, found_in;
   logic [IDXW-1:0] f_ff, f_in;
   logic [RW-1:0] frank_ff, frank_in;
   logic [lfu_pkg::VALUE_W-1:0] fval_ff, fval_in;
   logic [CNTW-1:0] used_ff, used_in;
   logic finv_ok_ff, finv_ok_in;
   logic [IDXW-1:0] finv_ff, finv_in;
   logic vfound_ff, vfound_in;
   logic [IDXW-1:0] v_ff, v_in;
   logic [lfu_pkg::COUNT_W-1:0] vcnt_ff, vcnt_in;
   logic [RW-1:0] vrank_ff, vrank_in;

   logic touch_ff, touch_in;
   logic insert_ff, insert_in;
   logic evict_ff, evict_in;
   logic [IDXW-1:0] slot_ff, slot_in;

   logic rsp_strobe_ff, rsp_strobe_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic [lfu_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [IDXW-1:0] pidx;
   logic [WORD_W-1:0] rd_data, wr_data;
   logic wr_en;
   logic [lfu_pkg::KEY_W-1:0]   d_key;
   logic [lfu_pkg::VALUE_W-1:0] d_val;
   logic [lfu_pkg::COUNT_W-1:0] d_cnt, d_cnt_inc;
   logic [RW-1:0] d_rank;
   logic [8:0] cap_eff, used_ext;
   logic accept;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = start && !busy;
   assign pidx      = IDXW'(cnt_ff - CNTW'(1));

   assign d_rank = rd_data[RW-1:0];
   assign d_cnt  = rd_data[RW +: lfu_pkg::COUNT_W];
   assign d_val  = rd_data[RW + lfu_pkg::COUNT_W +: lfu_pkg::VALUE_W];
   assign d_key  = rd_data[WORD_W-1 -: lfu_pkg::KEY_W];
   assign d_cnt_inc = (d_cnt == lfu_pkg::COUNT_MAX) ? d_cnt : d_cnt + 1'b1;

   assign cap_eff  = (9'(cap_ff) > 9'(CAPACITY)) ? 9'(CAPACITY) : 9'(cap_ff);
   assign used_ext = 9'(used_ff);

   lfu_entry_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDXW),
      .WORD_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .rd_addr (cnt_ff[IDXW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (pidx),
      .wr_data (wr_data)
   );

   always_comb begin
      state_in = state_ff;  cnt_in = cnt_ff;  valid_in = valid_ff;
      cap_in = cap_ff;  act_in = act_ff;  key_in = key_ff;  wval_in = wval_ff;
      found_in = found_ff;  f_in = f_ff;  frank_in = frank_ff;  fval_in = fval_ff;
      used_in = used_ff;  finv_ok_in = finv_ok_ff;  finv_in = finv_ff;
      vfound_in = vfound_ff;  v_in = v_ff;  vcnt_in = vcnt_ff;  vrank_in = vrank_ff;
      touch_in = touch_ff;  insert_in = insert_ff;  evict_in = evict_ff;
      slot_in = slot_ff;
      rsp_strobe_in = 1'b0;  rsp_hit_in = rsp_hit_ff;  rsp_value_in = rsp_value_ff;
      wr_en = 1'b0;
      wr_data = rd_data;

      if (csr_valid && csr_ready) begin
         cap_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in = req_action;  key_in = req_lookup_key;  wval_in = req_write_value;
               found_in = 1'b0;  used_in = '0;  finv_ok_in = 1'b0;  vfound_in = 1'b0;
               cnt_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               if (valid_ff[pidx]) begin
                  used_in = used_ff + 1'b1;
                  if (!found_ff && d_key == key_ff) begin
                     found_in = 1'b1;  f_in = pidx;  frank_in = d_rank;  fval_in = d_val;
                  end
                  if (!vfound_ff || d_cnt < vcnt_ff ||
                      (d_cnt == vcnt_ff && d_rank > vrank_ff)) begin
                     vfound_in = 1'b1;  v_in = pidx;  vcnt_in = d_cnt;  vrank_in = d_rank;
                  end
               end else if (!finv_ok_ff) begin
                  finv_ok_in = 1'b1;  finv_in = pidx;
               end
               if (cnt_ff == CAP_N) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            touch_in  = found_ff && (act_ff == lfu_pkg::ACT_GET || cap_eff != '0);
            evict_in  = (act_ff == lfu_pkg::ACT_PUT) && !found_ff && cap_eff != '0 &&
                        used_ext >= cap_eff && vfound_ff;
            insert_in = (act_ff == lfu_pkg::ACT_PUT) && !found_ff && cap_eff != '0 &&
                        (finv_ok_ff || evict_in);
            slot_in   = (evict_in && (!finv_ok_ff || v_ff < finv_ff)) ? v_ff : finv_ff;
            rsp_strobe_in = 1'b1;
            rsp_hit_in    = found_ff;
            rsp_value_in  = (found_ff && act_ff == lfu_pkg::ACT_GET) ? fval_ff : '0;
            cnt_in = '0;
            state_in = (touch_in || insert_in) ? ST_UPD : ST_IDLE;
         end
         ST_UPD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               wr_en = 1'b1;
               if (touch_ff) begin
                  if (pidx == f_ff) begin
                     wr_data = {d_key, (act_ff == lfu_pkg::ACT_PUT) ? wval_ff : d_val,
                                d_cnt_inc, RW'(0)};
                  end else if (valid_ff[pidx] && d_rank < frank_ff) begin
                     wr_data = {d_key, d_val, d_cnt, d_rank + 1'b1};
                  end
               end else begin
                  if (pidx == slot_ff) begin
                     wr_data = {key_ff, wval_ff, lfu_pkg::COUNT_W'(1), RW'(0)};
                     valid_in[pidx] = 1'b1;
                  end else if (evict_ff && pidx == v_ff) begin
                     valid_in[pidx] = 1'b0;
                  end else if (valid_ff[pidx]) begin
                     wr_data = {d_key, d_val, d_cnt,
                                d_rank - RW'(evict_ff && d_rank > vrank_ff) + 1'b1};
                  end
               end
               if (cnt_ff == CAP_N) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         cap_ff        <= lfu_pkg::CAP_RESET;
         rsp_strobe_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cnt_ff        <= cnt_in;
      end
      act_ff <= act_in;  key_ff <= key_in;  wval_ff <= wval_in;
      found_ff <= found_in;  f_ff <= f_in;  frank_ff <= frank_in;  fval_ff <= fval_in;
      used_ff <= used_in;  finv_ok_ff <= finv_ok_in;  finv_ff <= finv_in;
      vfound_ff <= vfound_in;  v_ff <= v_in;  vcnt_ff <= vcnt_in;  vrank_ff <= vrank_in;
      touch_ff <= touch_in;  insert_ff <= insert_in;  evict_ff <= evict_in;
      slot_ff <= slot_in;
      rsp_hit_ff <= rsp_hit_in;  rsp_value_ff <= rsp_value_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   // a transfer starts the scan pass
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCAN)
      else $error("accepted item did not enter scan");

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_DECIDE)
      else $error("result strobe outside decide");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held twice");

endmodule

// ===== rtl/core/lfu_entry_ram.sv =====
// ----------------------------------------------------------------------------
// lfu_entry_ram
// One-read one-write entry memory, registered read data.
// ----------------------------------------------------------------------------
module lfu_entry_ram #(
   parameter int DEPTH  = lfu_pkg::DEF_CAPACITY,
   parameter int ADDR_W = 4,
   parameter int WORD_W = 100
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
